// ----- src/sorted_key_table_search_unit_macros.svh -----
// Assertion macros shared by the key table search unit.
`ifndef SORTED_KEY_TABLE_SEARCH_UNIT_MACROS_SVH
`define SORTED_KEY_TABLE_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk outside of reset.
`define SKTS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk outside of reset.
`define SKTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/skts_pkg.sv -----
// Types and constants shared by the key table search unit.
package skts_pkg;

  localparam int POS_W       = 7;
  localparam int PROBE_W     = 8;
  localparam int KEY_FIELD_W = 16;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SORT   = 2'd1,
    CMD_LINEAR = 2'd2,
    CMD_BINARY = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LIN,
    ST_BIN,
    ST_SORT_RD_A,
    ST_SORT_LD_A,
    ST_SORT_SCAN,
    ST_SORT_WR_A,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   position;
    logic [PROBE_W-1:0] probes;
  } result_t;

endpackage

// ----- src/sorted_key_table_search_unit.sv -----
// Key table with load, exchange sort, linear search and binary search commands.
//
// The table of ENTRIES keys sits in one memory with a single registered read
// port. After reset a clearing pass writes zero to all ENTRIES words, one per
// cycle, while in_tready stays low. Each accepted item gives one result item;
// the result moves into the output register once that register is free. A
// linear search probes the positions in order; a binary search takes at most 8
// probes for 128 entries. One item is worked at a time; the next item is taken
// as soon as the previous result has left for the output register.
`include "sorted_key_table_search_unit_macros.svh"

module sorted_key_table_search_unit #(
  parameter int ENTRIES   = 128,
  parameter int KEY_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // command
  input  logic [39:0] in_tdata,   // entry_index, key_value, range_low, range_high, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // found, position, probes
);

  localparam int AW = $clog2(ENTRIES);

  logic                 in_accept;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [KEY_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [KEY_WIDTH-1:0] ram_rdata;
  logic                 res_valid;
  logic                 res_take;
  skts_pkg::result_t    res;

  logic                 out_tvalid_r, out_tvalid_nxt;
  skts_pkg::result_t    out_res_r, out_res_nxt;

  assign in_accept = in_tvalid && in_tready;

  skts_ctrl #(
    .ENTRIES   (ENTRIES),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_cmd    (skts_pkg::cmd_t'(in_tuser)),
    .in_index  (in_tdata[6:0]),
    .in_key    (in_tdata[22:7]),
    .in_low    (in_tdata[29:23]),
    .in_high   (in_tdata[36:30]),
    .ready     (in_tready),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  skts_key_ram #(
    .ENTRIES   (ENTRIES),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The output register frees the sequencer while a result waits downstream.
  assign res_take = res_valid && (!out_tvalid_r || out_tready);

  always_comb begin
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_res_nxt    = out_res_r;
    if (res_take) begin
      out_tvalid_nxt = 1'b1;
      out_res_nxt    = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_res_r.probes, out_res_r.position, out_res_r.found};

  `SKTS_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")
  `SKTS_ASSERT_IMPLY(a_miss_at_zero, out_tvalid_r && !out_res_r.found, out_res_r.position == '0, "miss with position")
  `SKTS_ASSERT_IMPLY(a_hit_probed, out_tvalid_r && out_res_r.found, out_res_r.probes != '0, "hit without probe")

endmodule

// ----- src/skts_key_ram.sv -----
// Key table memory: one write port and one read port with registered read data.
module skts_key_ram #(
  parameter int ENTRIES   = 128,
  parameter int KEY_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(ENTRIES)-1:0] waddr,
  input  logic [KEY_WIDTH-1:0]       wdata,
  input  logic [$clog2(ENTRIES)-1:0] raddr,
  output logic [KEY_WIDTH-1:0]       rdata
);

  logic [KEY_WIDTH-1:0] mem [ENTRIES];
  logic [KEY_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/skts_ctrl.sv -----
// Command sequencer: clearing pass, load, exchange sort, linear and binary search.
module skts_ctrl #(
  parameter int ENTRIES   = 128,
  parameter int KEY_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_accept,
  input  skts_pkg::cmd_t                      in_cmd,
  input  logic [skts_pkg::POS_W-1:0]          in_index,
  input  logic [skts_pkg::KEY_FIELD_W-1:0]    in_key,
  input  logic [skts_pkg::POS_W-1:0]          in_low,
  input  logic [skts_pkg::POS_W-1:0]          in_high,
  output logic                                ready,
  output logic                                ram_we,
  output logic [$clog2(ENTRIES)-1:0]          ram_waddr,
  output logic [KEY_WIDTH-1:0]                ram_wdata,
  output logic [$clog2(ENTRIES)-1:0]          ram_raddr,
  input  logic [KEY_WIDTH-1:0]                ram_rdata,
  output logic                                res_valid,
  output skts_pkg::result_t                   res,
  input  logic                                res_take
);

  localparam int AW = $clog2(ENTRIES);
  localparam int PW = skts_pkg::POS_W;

  skts_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]                   a_r, a_nxt;
  logic [AW-1:0]                   b_r, b_nxt;
  logic [KEY_WIDTH-1:0]            cur_r, cur_nxt;
  logic [KEY_WIDTH-1:0]            key_r, key_nxt;
  logic signed [8:0]               lo_r, lo_nxt;
  logic signed [8:0]               hi_r, hi_nxt;
  logic [PW-1:0]                   pos_r, pos_nxt;
  logic [PW-1:0]                   last_r, last_nxt;
  logic [skts_pkg::PROBE_W-1:0]    count_r, count_nxt, count_inc;
  skts_pkg::result_t               res_r, res_nxt;

  logic [KEY_WIDTH-1:0] key_in;
  logic [PW-1:0]        hi_clamp;
  logic [PW:0]          sum0;
  logic [PW-1:0]        mid0;
  logic                 empty0;
  logic                 key_hit, key_less, lin_end;
  logic signed [9:0]    mid_s, lo_s, hi_s, sum_lo, sum_hi;
  logic [PW-1:0]        mid_lo, mid_hi;
  logic                 empty_lo, empty_hi, bin_end;
  logic                 sort_swap, sort_b_end, sort_a_end, clr_end;

  // Key field masked or zero-extended to the table width.
  always_comb begin
    key_in = '0;
    for (int i = 0; i < skts_pkg::KEY_FIELD_W; i++) begin
      if (i < KEY_WIDTH) begin
        key_in[i] = in_key[i];
      end
    end
  end

  assign hi_clamp = (int'(in_high) > ENTRIES - 1) ? PW'(ENTRIES - 1) : in_high;
  assign sum0     = {1'b0, in_low} + {1'b0, hi_clamp};
  assign mid0     = sum0[PW:1];
  assign empty0   = in_low > hi_clamp;

  assign key_hit   = ram_rdata == key_r;
  assign key_less  = key_r < ram_rdata;
  assign lin_end   = pos_r == last_r;
  assign count_inc = count_r + 8'd1;

  // Both possible next midpoints are formed from registers, so the compare only selects.
  assign mid_s    = $signed({3'b000, pos_r});
  assign lo_s     = {lo_r[8], lo_r};
  assign hi_s     = {hi_r[8], hi_r};
  assign sum_lo   = lo_s + mid_s - 10'sd1;
  assign sum_hi   = mid_s + 10'sd1 + hi_s;
  assign mid_lo   = sum_lo[PW:1];
  assign mid_hi   = sum_hi[PW:1];
  assign empty_lo = lo_s > (mid_s - 10'sd1);
  assign empty_hi = (mid_s + 10'sd1) > hi_s;
  assign bin_end  = key_less ? empty_lo : empty_hi;

  assign sort_swap  = cur_r > ram_rdata;
  assign sort_b_end = b_r == AW'(ENTRIES - 1);
  assign sort_a_end = a_r == AW'(ENTRIES - 2);
  assign clr_end    = a_r == AW'(ENTRIES - 1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      skts_pkg::ST_CLEAR: begin
        if (clr_end) begin
          state_nxt = skts_pkg::ST_IDLE;
        end
      end
      skts_pkg::ST_IDLE: begin
        if (in_accept) begin
          unique case (in_cmd)
            skts_pkg::CMD_LOAD:   state_nxt = skts_pkg::ST_DONE;
            skts_pkg::CMD_SORT:   state_nxt = skts_pkg::ST_SORT_RD_A;
            skts_pkg::CMD_LINEAR: state_nxt = empty0 ? skts_pkg::ST_DONE : skts_pkg::ST_LIN;
            skts_pkg::CMD_BINARY: state_nxt = empty0 ? skts_pkg::ST_DONE : skts_pkg::ST_BIN;
            default:              state_nxt = skts_pkg::ST_DONE;
          endcase
        end
      end
      skts_pkg::ST_LIN: begin
        if (key_hit || lin_end) begin
          state_nxt = skts_pkg::ST_DONE;
        end
      end
      skts_pkg::ST_BIN: begin
        if (key_hit || bin_end) begin
          state_nxt = skts_pkg::ST_DONE;
        end
      end
      skts_pkg::ST_SORT_RD_A: state_nxt = skts_pkg::ST_SORT_LD_A;
      skts_pkg::ST_SORT_LD_A: state_nxt = skts_pkg::ST_SORT_SCAN;
      skts_pkg::ST_SORT_SCAN: begin
        if (sort_b_end) begin
          state_nxt = skts_pkg::ST_SORT_WR_A;
        end
      end
      skts_pkg::ST_SORT_WR_A: begin
        state_nxt = sort_a_end ? skts_pkg::ST_DONE : skts_pkg::ST_SORT_RD_A;
      end
      skts_pkg::ST_DONE: begin
        if (res_take) begin
          state_nxt = skts_pkg::ST_IDLE;
        end
      end
      default: state_nxt = skts_pkg::ST_IDLE;
    endcase
  end

  // During a sort pass the key at position a lives in cur_r; the table copy is
  // stale until the pass writes it back, and nothing reads it in between.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = a_r;
    ram_wdata = cur_r;
    ram_raddr = b_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    cur_nxt   = cur_r;
    key_nxt   = key_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    pos_nxt   = pos_r;
    last_nxt  = last_r;
    count_nxt = count_r;
    res_nxt   = res_r;
    unique case (state_r)
      skts_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        a_nxt     = a_r + AW'(1);
      end
      skts_pkg::ST_IDLE: begin
        if (in_accept) begin
          key_nxt   = key_in;
          count_nxt = '0;
          res_nxt   = '0;
          unique case (in_cmd)
            skts_pkg::CMD_LOAD: begin
              if (int'(in_index) < ENTRIES) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(in_index);
                ram_wdata = key_in;
              end
            end
            skts_pkg::CMD_SORT: begin
              a_nxt = '0;
            end
            skts_pkg::CMD_LINEAR: begin
              ram_raddr = AW'(in_low);
              pos_nxt   = in_low;
              last_nxt  = hi_clamp;
            end
            skts_pkg::CMD_BINARY: begin
              ram_raddr = AW'(mid0);
              pos_nxt   = mid0;
              lo_nxt    = $signed({2'b00, in_low});
              hi_nxt    = $signed({2'b00, hi_clamp});
            end
            default: begin
            end
          endcase
        end
      end
      skts_pkg::ST_LIN: begin
        if (key_hit) begin
          res_nxt = '{found: 1'b1, position: pos_r, probes: count_inc};
        end else if (lin_end) begin
          res_nxt = '{found: 1'b0, position: '0, probes: count_inc};
        end else begin
          ram_raddr = AW'(pos_r + PW'(1));
          pos_nxt   = pos_r + PW'(1);
          count_nxt = count_inc;
        end
      end
      skts_pkg::ST_BIN: begin
        if (key_hit) begin
          res_nxt = '{found: 1'b1, position: pos_r, probes: count_inc};
        end else if (bin_end) begin
          res_nxt = '{found: 1'b0, position: '0, probes: count_inc};
        end else begin
          count_nxt = count_inc;
          if (key_less) begin
            hi_nxt    = 9'(mid_s - 10'sd1);
            pos_nxt   = mid_lo;
            ram_raddr = AW'(mid_lo);
          end else begin
            lo_nxt    = 9'(mid_s + 10'sd1);
            pos_nxt   = mid_hi;
            ram_raddr = AW'(mid_hi);
          end
        end
      end
      skts_pkg::ST_SORT_RD_A: begin
        ram_raddr = a_r;
        b_nxt     = a_r + AW'(1);
      end
      skts_pkg::ST_SORT_LD_A: begin
        cur_nxt   = ram_rdata;
        ram_raddr = b_r;
      end
      skts_pkg::ST_SORT_SCAN: begin
        if (sort_swap) begin
          ram_we    = 1'b1;
          ram_waddr = b_r;
          ram_wdata = cur_r;
          cur_nxt   = ram_rdata;
        end
        if (!sort_b_end) begin
          b_nxt     = b_r + AW'(1);
          ram_raddr = b_r + AW'(1);
        end
      end
      skts_pkg::ST_SORT_WR_A: begin
        ram_we    = 1'b1;
        ram_waddr = a_r;
        ram_wdata = cur_r;
        a_nxt     = a_r + AW'(1);
      end
      skts_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= skts_pkg::ST_CLEAR;
      a_r     <= '0;
    end else begin
      state_r <= state_nxt;
      a_r     <= a_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r     <= b_nxt;
    cur_r   <= cur_nxt;
    key_r   <= key_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    pos_r   <= pos_nxt;
    last_r  <= last_nxt;
    count_r <= count_nxt;
    res_r   <= res_nxt;
  end

  assign ready     = state_r == skts_pkg::ST_IDLE;
  assign res_valid = state_r == skts_pkg::ST_DONE;
  assign res       = res_r;

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the key table search unit.
module tb_top;
  import skts_pkg::*;

  localparam int ENTRIES     = 128;
  localparam int CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;   // command
  logic [39:0] in_tdata;   // entry_index, key_value, range_low, range_high, zero pad
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // found, position, probes

  logic [KEY_FIELD_W-1:0] key_image [0:ENTRIES-1];
  result_t                pending_results [$];
  int                     error_count;
  int                     cycle_count;
  int                     quiet_items;

  sorted_key_table_search_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Applies one command to the table image and returns the result it should give.
  function automatic result_t apply_table_command(cmd_t cmd, logic [POS_W-1:0] idx,
                                                  logic [KEY_FIELD_W-1:0] key,
                                                  logic [POS_W-1:0] lo_in,
                                                  logic [POS_W-1:0] hi_in);
    result_t                res;
    int                     lo;
    int                     hi;
    int                     mid;
    int                     count;
    logic [KEY_FIELD_W-1:0] swap;
    res   = '0;
    lo    = lo_in;
    hi    = (hi_in > ENTRIES - 1) ? ENTRIES - 1 : hi_in;
    count = 0;
    case (cmd)
      CMD_LOAD: begin
        if (idx < ENTRIES) key_image[idx] = key;
      end
      CMD_SORT: begin
        for (int a = 0; a < ENTRIES - 1; a++) begin
          for (int b = a + 1; b < ENTRIES; b++) begin
            if (key_image[a] > key_image[b]) begin
              swap         = key_image[a];
              key_image[a] = key_image[b];
              key_image[b] = swap;
            end
          end
        end
      end
      CMD_LINEAR: begin
        for (int p = lo; p <= hi; p++) begin
          count++;
          if (key_image[p] == key) begin
            res.found    = 1'b1;
            res.position = p[POS_W-1:0];
            break;
          end
        end
        res.probes = (count > 255) ? 8'd255 : count[PROBE_W-1:0];
      end
      default: begin
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          count++;
          if (key_image[mid] == key) begin
            res.found    = 1'b1;
            res.position = mid[POS_W-1:0];
            break;
          end
          if (key < key_image[mid]) hi = mid - 1;
          else lo = mid + 1;
        end
        res.probes = (count > 255) ? 8'd255 : count[PROBE_W-1:0];
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Mostly short gaps, a few long ones, and now and then a run of items back to back.
  function automatic int pick_send_gap();
    int r;
    if (quiet_items > 0) begin
      quiet_items--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      quiet_items = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(cmd_t cmd, logic [POS_W-1:0] idx, logic [KEY_FIELD_W-1:0] key,
                           logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
    int gap;
    gap = pick_send_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  = cmd;
    in_tdata  = {3'b000, hi, lo, key, idx};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_table_command(cmd, idx, key, lo, hi));
  endtask

  // Stops sending and waits until every outstanding result has been returned.
  task automatic wait_for_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_search(cmd_t cmd);
    logic [KEY_FIELD_W-1:0] key;
    logic [POS_W-1:0]       lo;
    logic [POS_W-1:0]       hi;
    logic [POS_W-1:0]       swap;
    int                     r;
    if ($urandom_range(0, 99) < 75) key = key_image[POS_W'($urandom_range(0, ENTRIES - 1))];
    else key = KEY_FIELD_W'($urandom);
    lo = POS_W'($urandom_range(0, ENTRIES - 1));
    hi = POS_W'($urandom_range(0, ENTRIES - 1));
    r  = $urandom_range(0, 99);
    if (r < 60) begin
      lo = '0;
      hi = POS_W'(ENTRIES - 1);
    end else if (r < 90 && lo > hi) begin
      swap = lo;
      lo   = hi;
      hi   = swap;
    end
    send_item(cmd, POS_W'($urandom), key, lo, hi);
  endtask

  // Searches on the table as it stands right after the clearing pass.
  task automatic test_cleared_table();
    send_item(CMD_LINEAR, 7'd0, 16'h0000, 7'd5, 7'd9);
    send_item(CMD_LINEAR, 7'd127, 16'hFFFF, 7'd0, 7'd127);
    send_item(CMD_BINARY, 7'd0, 16'h0000, 7'd0, 7'd127);
    send_item(CMD_BINARY, 7'd0, 16'h1234, 7'd0, 7'd127);
    send_item(CMD_LINEAR, 7'd0, 16'h0000, 7'd100, 7'd3);
    send_item(CMD_BINARY, 7'd0, 16'h0000, 7'd127, 7'd0);
    send_item(CMD_LINEAR, 7'd0, 16'h0000, 7'd127, 7'd127);
  endtask

  // Loads at and near the table ends and at its middle, binary and linear searches before and after a sort.
  task automatic test_load_sort_search();
    send_item(CMD_LOAD, 7'd0, 16'hFFFF, 7'd127, 7'd127);
    send_item(CMD_LOAD, 7'd127, 16'h0001, 7'd0, 7'd0);
    send_item(CMD_LOAD, 7'd64, 16'h8000, 7'd0, 7'd0);
    send_item(CMD_LOAD, 7'd1, 16'h7FFF, 7'd0, 7'd0);
    send_item(CMD_LOAD, 7'd126, 16'h5555, 7'd0, 7'd0);
    // The table is not in order yet, so this probing can miss a present key.
    send_item(CMD_BINARY, 7'd0, 16'hFFFF, 7'd0, 7'd127);
    send_item(CMD_LINEAR, 7'd0, 16'hFFFF, 7'd0, 7'd127);
    send_item(CMD_SORT, 7'd127, 16'hFFFF, 7'd127, 7'd127);
    send_item(CMD_BINARY, 7'd0, 16'hFFFF, 7'd0, 7'd127);
    send_item(CMD_BINARY, 7'd0, 16'h0001, 7'd0, 7'd127);
    send_item(CMD_BINARY, 7'd0, 16'h8000, 7'd0, 7'd127);
    send_item(CMD_LINEAR, 7'd0, 16'h5555, 7'd0, 7'd127);
    send_item(CMD_BINARY, 7'd0, 16'h4444, 7'd0, 7'd127);
    send_item(CMD_BINARY, 7'd0, 16'h0000, 7'd0, 7'd0);
    send_item(CMD_LINEAR, 7'd0, 16'hAAAA, 7'd127, 7'd126);
  endtask

  // Rounds of random loads, a sort, then searches that mostly look for stored keys.
  task automatic test_sorted_table_lookups();
    int                     lookup_items;
    int                     loads;
    int                     searches;
    int                     r;
    logic [KEY_FIELD_W-1:0] key_span;
    lookup_items = 0;
    while (lookup_items < 1000) begin
      loads    = $urandom_range(4, 40);
      key_span = ($urandom_range(0, 2) == 0) ? 16'h000F : 16'hFFFF;
      repeat (loads) send_item(CMD_LOAD, POS_W'($urandom), KEY_FIELD_W'($urandom) & key_span,
                               POS_W'($urandom), POS_W'($urandom));
      send_item(CMD_SORT, POS_W'($urandom), KEY_FIELD_W'($urandom), POS_W'($urandom),
                POS_W'($urandom));
      searches = $urandom_range(20, 50);
      repeat (searches) begin
        r = $urandom_range(0, 99);
        if (r < 5) send_item(CMD_LOAD, POS_W'($urandom), KEY_FIELD_W'($urandom),
                             POS_W'($urandom), POS_W'($urandom));
        else if (r < 70) send_random_search(CMD_BINARY);
        else send_random_search(CMD_LINEAR);
      end
      lookup_items += loads + 1 + searches;
    end
  endtask

  // Random loads and searches with no sort, so binary searches see disorder.
  task automatic test_unsorted_searches();
    int r;
    repeat (80) begin
      r = $urandom_range(0, 2);
      if (r == 0) send_item(CMD_LOAD, POS_W'($urandom), KEY_FIELD_W'($urandom),
                            POS_W'($urandom), POS_W'($urandom));
      else if (r == 1) send_random_search(CMD_LINEAR);
      else send_random_search(CMD_BINARY);
    end
  endtask

  // Short bursts, each followed by a full drain before the next one starts.
  task automatic test_drain_between_bursts();
    repeat (3) begin
      repeat (10) send_random_search($urandom_range(0, 1) ? CMD_BINARY : CMD_LINEAR);
      wait_for_results();
    end
  endtask

  initial begin
    int ready_hold;
    int r;
    out_tready = 1'b0;
    ready_hold = 0;
    forever begin
      @(negedge clk);
      if (ready_hold > 0) begin
        ready_hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_tready = 1'b1;
          ready_hold = $urandom_range(0, 5);
        end else if (r < 85) begin
          out_tready = 1'b0;
          ready_hold = $urandom_range(0, 3);
        end else if (r < 95) begin
          out_tready = 1'b0;
          ready_hold = $urandom_range(10, 60);
        end else begin
          out_tready = 1'b1;
          ready_hold = $urandom_range(100, 300);
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t                want;
    logic                   got_found;
    logic [POS_W-1:0]       got_position;
    logic [PROBE_W-1:0]     got_probes;
    if (rst_n && out_tvalid && out_tready) begin
      got_found    = out_tdata[0];
      got_position = out_tdata[7:1];
      got_probes   = out_tdata[15:8];
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result item 0x%04h", out_tdata));
      end else begin
        want = pending_results.pop_front();
        if (got_found != want.found)
          report_mismatch($sformatf("found %0d, want %0d", got_found, want.found));
        if (got_position != want.position)
          report_mismatch($sformatf("position %0d, want %0d", got_position, want.position));
        if (got_probes != want.probes)
          report_mismatch($sformatf("probes %0d, want %0d", got_probes, want.probes));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    cycle_count = 0;
    quiet_items = 0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = CMD_LOAD;
    in_tdata    = '0;
    for (int i = 0; i < ENTRIES; i++) key_image[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_cleared_table();
    test_load_sort_search();
    test_drain_between_bursts();
    test_unsorted_searches();
    test_sorted_table_lookups();

    wait_for_results();
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/skts_pkg.sv
src/skts_key_ram.sv
src/skts_ctrl.sv
src/sorted_key_table_search_unit.sv
sim/tb_top.sv
